>>> src/complex_fir_real_taps_assert.svh
// Assertion macros for the complex FIR block.
`ifndef COMPLEX_FIR_REAL_TAPS_ASSERT_SVH
`define COMPLEX_FIR_REAL_TAPS_ASSERT_SVH
`ifndef SYNTHESIS
`define CFIR_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("complex_fir_real_taps: assertion failed");
`define CFIR_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("complex_fir_real_taps: assertion failed");
`else
`define CFIR_ASSERT_IMPL(label, ck, rn, ante, cons)
`define CFIR_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

>>> src/cfir_pkg.sv
`default_nettype none

package cfir_pkg;

    localparam int MAX_TAPS    = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_SHIFT  = 14;
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int QW          = ACC_W - FRAC_SHIFT;
    localparam int CNT_W       = $clog2(MAX_TAPS + 1);

    localparam int NUM_REGS      = 5;
    localparam int COEFS_PER_REG = 4;
    localparam int COEF_REGS     = 4;
    localparam int COEF_TAPS     = COEF_REGS * COEFS_PER_REG;
    localparam int DATA_W        = 64;
    localparam int ADDR_W        = $clog2(8 * NUM_REGS);
    localparam int REG_IDX_W     = ADDR_W - 3;
    localparam int TAP_COUNT_W   = 5;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef coef_t [MAX_TAPS-1:0]          coef_arr_t;
    typedef logic [REG_IDX_W-1:0]          reg_idx_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    localparam reg_idx_t REG_TAP_COUNT   = REG_IDX_W'(0);
    localparam reg_idx_t REG_COEF_0_3    = REG_IDX_W'(1);
    localparam reg_idx_t REG_COEF_4_7    = REG_IDX_W'(2);
    localparam reg_idx_t REG_COEF_8_11   = REG_IDX_W'(3);
    localparam reg_idx_t REG_COEF_12_15  = REG_IDX_W'(4);

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = TAP_COUNT_W'(16);
    localparam logic [DATA_W-1:0]      COEF0_RST     = DATA_W'(16384);

    localparam acc_t RND_HALF = ACC_W'(2 ** (FRAC_SHIFT - 1));
    localparam logic signed [QW-1:0] Q_MAX = QW'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(2 ** (SAMPLE_BITS - 1));

    // Round half up by FRAC_SHIFT bits, then saturate to the sample range.
    function automatic sample_t round_sat(acc_t acc);
        acc_t                   x;
        logic signed [QW-1:0]   q;
        sample_t                r;
        x = acc + RND_HALF;
        q = x[ACC_W-1:FRAC_SHIFT];
        if (q > Q_MAX)
        begin
            q = Q_MAX;
        end
        else if (q < Q_MIN)
        begin
            q = Q_MIN;
        end
        r = q[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/complex_fir_real_taps.sv
`default_nettype none

// FIR filter for complex I/Q samples with real Q2.14 coefficients, one I/Q result word per
// input word. An enabled word is shifted into a chain of 16 cells, one delay tap per cell;
// the partial sums for I and Q then ripple through the chain, one cell per cycle, and the
// full sum is rounded and saturated to Q1.15. After acceptance an enabled word stays in the
// RUN state while the sum ripples through the chain, then in the FINISH state, which parks
// the result in the output register once it is free, before the block takes the next word;
// a disabled word goes straight to FINISH. The output register lets the next word enter
// while a result still waits. Writing tap_count clears the delay line; configuration must be
// written over the APB port only while the block is idle, which the block does not enforce.
module complex_fir_real_taps (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [cfir_pkg::ADDR_W-1:0]          paddr,
    input  wire  [cfir_pkg::DATA_W-1:0]          pwdata,
    output logic [cfir_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  cfir_pkg::sample_t                    sample_i,
    input  cfir_pkg::sample_t                    sample_q,
    input  wire                                  enable,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output cfir_pkg::sample_t                    out_i,
    output cfir_pkg::sample_t                    out_q
);
    import cfir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    sample_t           res_i_reg, res_q_reg, res_i_next, res_q_next;
    sample_t           out_i_reg, out_q_reg;
    logic              in_acc, out_load, cfg_wr, cfg_clear;
    coef_arr_t         coefs;
    cell_ctl_t         ctl;
    sample_t           smp_i [MAX_TAPS];
    sample_t           smp_q [MAX_TAPS];
    acc_t              psum_i [MAX_TAPS];
    acc_t              psum_q [MAX_TAPS];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    cfir_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_wr),
        .wr_idx  (paddr[ADDR_W-1:3]),
        .wr_data (pwdata),
        .rd_idx  (paddr[ADDR_W-1:3]),
        .rd_data (prdata),
        .coefs   (coefs),
        .clear   (cfg_clear)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign ctl.shift = in_acc && enable;
    assign ctl.clear = cfg_clear;

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        cfir_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .smp_i_in   ((k == 0) ? sample_i : smp_i[(k == 0) ? 0 : k - 1]),
            .smp_q_in   ((k == 0) ? sample_q : smp_q[(k == 0) ? 0 : k - 1]),
            .coef       (coefs[k]),
            .psum_i_in  ((k == 0) ? acc_t'('0) : psum_i[(k == 0) ? 0 : k - 1]),
            .psum_q_in  ((k == 0) ? acc_t'('0) : psum_q[(k == 0) ? 0 : k - 1]),
            .smp_i_out  (smp_i[k]),
            .smp_q_out  (smp_q[k]),
            .psum_i_out (psum_i[k]),
            .psum_q_out (psum_q[k])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        res_i_next = res_i_reg;
        res_q_next = res_q_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (enable)
                    begin
                        cnt_next   = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        res_i_next = sample_i;
                        res_q_next = sample_q;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                // By now the sum has passed every cell of the chain.
                if (cnt_reg == CNT_W'(MAX_TAPS))
                begin
                    res_i_next = round_sat(psum_i[MAX_TAPS-1]);
                    res_q_next = round_sat(psum_q[MAX_TAPS-1]);
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_i_reg <= res_i_next;
        res_q_reg <= res_q_next;
        if (out_load)
        begin
            out_i_reg <= res_i_reg;
            out_q_reg <= res_q_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_i     = out_i_reg;
    assign out_q     = out_q_reg;

`include "complex_fir_real_taps_assert.svh"

    `CFIR_ASSERT_NEXT(a_run_start, clk, rst_n, in_acc && enable, state_reg == ST_RUN && cnt_reg == '0)
    `CFIR_ASSERT_NEXT(a_bypass, clk, rst_n, in_acc && !enable, res_i_reg == $past(sample_i) && res_q_reg == $past(sample_q))
    `CFIR_ASSERT_IMPL(a_out_load, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_FINISH)
    `CFIR_ASSERT_IMPL(a_run_bound, clk, rst_n, state_reg == ST_RUN, cnt_reg <= CNT_W'(MAX_TAPS))

endmodule

`default_nettype wire

>>> src/cfir_cell.sv
`default_nettype none

module cfir_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  cfir_pkg::cell_ctl_t  ctl,
    input  cfir_pkg::sample_t    smp_i_in,
    input  cfir_pkg::sample_t    smp_q_in,
    input  cfir_pkg::coef_t      coef,
    input  cfir_pkg::acc_t       psum_i_in,
    input  cfir_pkg::acc_t       psum_q_in,
    output cfir_pkg::sample_t    smp_i_out,
    output cfir_pkg::sample_t    smp_q_out,
    output cfir_pkg::acc_t       psum_i_out,
    output cfir_pkg::acc_t       psum_q_out
);
    import cfir_pkg::*;

    sample_t                   smp_i_reg, smp_q_reg;
    sample_t                   smp_i_next, smp_q_next;
    acc_t                      psum_i_reg, psum_q_reg;
    logic signed [PROD_W-1:0]  prod_i, prod_q;

    always_comb
    begin
        priority if (ctl.clear)
        begin
            smp_i_next = '0;
            smp_q_next = '0;
        end
        else if (ctl.shift)
        begin
            smp_i_next = smp_i_in;
            smp_q_next = smp_q_in;
        end
        else
        begin
            smp_i_next = smp_i_reg;
            smp_q_next = smp_q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_i_reg <= '0;
            smp_q_reg <= '0;
        end
        else
        begin
            smp_i_reg <= smp_i_next;
            smp_q_reg <= smp_q_next;
        end
    end

    assign prod_i = coef * smp_i_reg;
    assign prod_q = coef * smp_q_reg;

    // The partial sum moves one cell along the chain every cycle.
    always_ff @(posedge clk)
    begin
        psum_i_reg <= psum_i_in + ACC_W'(prod_i);
        psum_q_reg <= psum_q_in + ACC_W'(prod_q);
    end

    assign smp_i_out  = smp_i_reg;
    assign smp_q_out  = smp_q_reg;
    assign psum_i_out = psum_i_reg;
    assign psum_q_out = psum_q_reg;

endmodule

`default_nettype wire

>>> src/cfir_cfg.sv
`default_nettype none

module cfir_cfg (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   wr_en,
    input  cfir_pkg::reg_idx_t                    wr_idx,
    input  wire [cfir_pkg::DATA_W-1:0]            wr_data,
    input  cfir_pkg::reg_idx_t                    rd_idx,
    output logic [cfir_pkg::DATA_W-1:0]           rd_data,
    output cfir_pkg::coef_arr_t                   coefs,
    output logic                                  clear
);
    import cfir_pkg::*;

    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic [DATA_W-1:0]      coef_reg [COEF_REGS];
    logic [CNT_W-1:0]       n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RST;
            coef_reg[0]   <= COEF0_RST;
            coef_reg[1]   <= '0;
            coef_reg[2]   <= '0;
            coef_reg[3]   <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_TAP_COUNT:  tap_count_reg <= wr_data[TAP_COUNT_W-1:0];
                REG_COEF_0_3:   coef_reg[0]   <= wr_data;
                REG_COEF_4_7:   coef_reg[1]   <= wr_data;
                REG_COEF_8_11:  coef_reg[2]   <= wr_data;
                REG_COEF_12_15: coef_reg[3]   <= wr_data;
                default:        ;
            endcase
        end
    end

    // A new tap count empties the delay line at the same edge.
    assign clear = wr_en && (wr_idx == REG_TAP_COUNT);

    always_comb
    begin
        unique case (rd_idx)
            REG_TAP_COUNT:  rd_data = DATA_W'(tap_count_reg);
            REG_COEF_0_3:   rd_data = coef_reg[0];
            REG_COEF_4_7:   rd_data = coef_reg[1];
            REG_COEF_8_11:  rd_data = coef_reg[2];
            REG_COEF_12_15: rd_data = coef_reg[3];
            default:        rd_data = '0;
        endcase
    end

    // A tap count of zero behaves as one, and anything past the chain length as the full chain.
    always_comb
    begin
        priority if (tap_count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(tap_count_reg) > MAX_TAPS)
        begin
            n_eff = CNT_W'(MAX_TAPS);
        end
        else
        begin
            n_eff = CNT_W'(tap_count_reg);
        end
    end

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_coef
        if (k < COEF_TAPS)
        begin : g_reg
            assign coefs[k] = (CNT_W'(k) < n_eff)
                ? coef_reg[k / COEFS_PER_REG][(k % COEFS_PER_REG) * COEF_BITS +: COEF_BITS]
                : '0;
        end
        else
        begin : g_zero
            assign coefs[k] = '0;
        end
    end

endmodule

`default_nettype wire
